>>> hdl/assert_macros.svh
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every clock edge while out of reset
`define SCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on every clock edge, reset included
`define SCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

>>> hdl/scs_pkg.sv
// Shared types and constants of the shrinking-cone segmenter
`default_nettype none
package scs_pkg;
  localparam int unsigned KeyW   = 64;
  localparam int unsigned SlopeW = 64;
  localparam int unsigned BaseW  = 32;
  localparam int unsigned ErrW   = 16;
  localparam logic [ErrW-1:0] ErrReset = 16'd32;
  localparam logic [SlopeW-1:0] SlopeMax = {1'b0, {(SlopeW-1){1'b1}}};
  localparam logic [SlopeW-1:0] SlopeMin = {1'b1, {(SlopeW-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHK, ST_DIV1, ST_CONE, ST_EMITC, ST_RESEED, ST_DIV2, ST_POST, ST_EMITF
  } st_e;

  // Strobes from the sequencer to the datapath registers
  typedef struct packed {
    logic take;
    logic first;
    logic div_start;
    logic cone_upd;
    logic emit_c;
    logic reseed_bnd;
    logic post;
    logic emit_f;
  } ctl_t;
endpackage
`default_nettype wire

>>> hdl/scs_if.sv
// Stream interfaces of the segmenter: key words in, segment words out
`default_nettype none
interface scs_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] key;
  logic               last_key;
  modport source (output valid, key, last_key, input ready);
  modport sink   (input valid, key, last_key, output ready);
endinterface

interface scs_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] seg_key;
  logic signed [63:0] slope;
  logic        [31:0] seg_rank;
  logic               last_of_run;
  logic               final_segment;
  modport source (output valid, seg_key, slope, seg_rank, last_of_run, final_segment,
                  input ready);
  modport sink   (input valid, seg_key, slope, seg_rank, last_of_run, final_segment,
                  output ready);
endinterface
`default_nettype wire

>>> hdl/shrinking_cone_segmenter.sv
// Shrinking-cone segmenter top level: sequencer, cone state and output register
// A sorted stream of signed 64-bit keys comes in one word at a time; each closed segment
// leaves as one word (start key, Q.SLOPE_FRAC_BITS slope, base rank). Both cone bounds of
// a key are divided at once by two bit-serial dividers, one quotient bit per cycle. A key
// that closes a segment starts a second division once its word is emitted, unless it
// equals the new origin; the first key of a stream or a key equal to the segment origin
// needs no division. A key marked last_key also flushes the open segment as a final word,
// and a stalled output word holds up the key in work. Only one key is in work at a time;
// a finished word waits in the output register while the next key is taken. The error
// bound must be written only while the block is idle; the block itself does not enforce
// this.
`default_nettype none
module shrinking_cone_segmenter #(
  parameter int unsigned RANK_BITS       = 32,
  parameter int unsigned SLOPE_FRAC_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  scs_in_if.sink           in_i,
  scs_out_if.source        out_o
);
  import scs_pkg::*;

  localparam int unsigned NB = RANK_BITS + 1;

  st_e  st_q, st_d;
  ctl_t ctl;

  logic [ErrW-1:0]      me_q;
  logic                 started_q;
  logic [RANK_BITS-1:0] rank_q, orank_q;
  logic [63:0]          okey_q, prev_q, slo_q, shi_q, key_q;
  logic                 lunb_q, hunb_q, last_q;

  logic                 out_valid_q;
  logic [63:0]          out_key_q, out_slope_q;
  logic [31:0]          out_rank_q;
  logic                 out_lor_q, out_fin_q;
  logic                 out_free;

  logic [RANK_BITS-1:0] rank_gap;
  logic [NB-1:0]        me_x, gap_x, nhi_mag, nlo_mag;
  logic                 nlo_neg, dneg, key_eq;
  logic [63:0]          dmag, qhi, qlo, nhi, nlo, cone_slope;
  logic [64:0]          mid_sum;
  logic [RANK_BITS+31:0] orank_ext;
  logic                 done_hi, done_lo, collapse;

  assign out_free = !out_valid_q || out_o.ready;
  assign key_eq   = key_q == okey_q;

  // Bound numerators and key distance
  assign rank_gap = rank_q - orank_q;
  assign me_x     = NB'(me_q);
  assign gap_x    = {1'b0, rank_gap};
  assign nhi_mag  = gap_x + me_x;
  assign nlo_neg  = gap_x < me_x;
  assign nlo_mag  = nlo_neg ? me_x - gap_x : gap_x - me_x;
  assign dneg     = $signed(key_q) < $signed(okey_q);
  assign dmag     = dneg ? okey_q - key_q : key_q - okey_q;

  scs_div #(.NB(NB), .FRAC(SLOPE_FRAC_BITS)) u_div_hi (
    .clk_i, .rst_ni, .start_i(ctl.div_start), .nmag_i(nhi_mag), .nneg_i(1'b0),
    .dmag_i(dmag), .dneg_i(dneg), .done_o(done_hi), .quo_o(qhi)
  );
  scs_div #(.NB(NB), .FRAC(SLOPE_FRAC_BITS)) u_div_lo (
    .clk_i, .rst_ni, .start_i(ctl.div_start), .nmag_i(nlo_mag), .nneg_i(nlo_neg),
    .dmag_i(dmag), .dneg_i(dneg), .done_o(done_lo), .quo_o(qlo)
  );

  // Narrow the cone against the new bounds
  assign nhi = (hunb_q || $signed(qhi) < $signed(shi_q)) ? qhi : shi_q;
  assign nlo = (lunb_q || $signed(slo_q) < $signed(qlo)) ? qlo : slo_q;
  assign collapse = $signed(nhi) < $signed(nlo);

  // Segment slope: cone midpoint (floor of the exact mean), else a set bound or 1.0
  assign mid_sum = {slo_q[63], slo_q} + {shi_q[63], shi_q};
  always_comb begin
    if (lunb_q && hunb_q) begin
      cone_slope = 64'd1 << SLOPE_FRAC_BITS;
    end else if (lunb_q) begin
      cone_slope = shi_q;
    end else if (hunb_q) begin
      cone_slope = slo_q;
    end else begin
      cone_slope = mid_sum[64:1];
    end
  end
  assign orank_ext = {32'd0, orank_q};

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:   if (in_i.valid) st_d = ST_CHK;
      ST_CHK:    st_d = (!started_q || key_eq) ? ST_POST : ST_DIV1;
      ST_DIV1:   if (done_hi && done_lo) st_d = ST_CONE;
      ST_CONE:   st_d = collapse ? ST_EMITC : ST_POST;
      ST_EMITC:  if (out_free) st_d = ST_RESEED;
      ST_RESEED: st_d = key_eq ? ST_POST : ST_DIV2;
      ST_DIV2:   if (done_hi && done_lo) st_d = ST_POST;
      ST_POST:   st_d = last_q ? ST_EMITF : ST_IDLE;
      ST_EMITF:  if (out_free) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  // Sequencer strobes
  always_comb begin
    ctl = '0;
    case (st_q)
      ST_IDLE:   ctl.take = in_i.valid;
      ST_CHK: begin
        ctl.first     = !started_q;
        ctl.div_start = started_q && !key_eq;
      end
      ST_CONE:   ctl.cone_upd = !collapse;
      ST_EMITC:  ctl.emit_c = out_free;
      ST_RESEED: ctl.div_start = !key_eq;
      ST_DIV2:   ctl.reseed_bnd = done_hi && done_lo;
      ST_POST:   ctl.post = 1'b1;
      ST_EMITF:  ctl.emit_f = out_free;
      default:   ctl = '0;
    endcase
  end

  assign in_i.ready = (st_q == ST_IDLE);

  // Control and stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      me_q        <= ErrReset;
      started_q   <= 1'b0;
      rank_q      <= '0;
      orank_q     <= '0;
      okey_q      <= '0;
      prev_q      <= '0;
      slo_q       <= '0;
      shi_q       <= '0;
      lunb_q      <= 1'b1;
      hunb_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) me_q <= cfg_wdata_i;
      if (ctl.first) begin
        started_q <= 1'b1;
        okey_q    <= key_q;
        orank_q   <= rank_q;
        lunb_q    <= 1'b1;
        hunb_q    <= 1'b1;
        slo_q     <= '0;
        shi_q     <= '0;
      end
      if (ctl.cone_upd || ctl.reseed_bnd) begin
        slo_q  <= ctl.cone_upd ? nlo : qlo;
        shi_q  <= ctl.cone_upd ? nhi : qhi;
        lunb_q <= 1'b0;
        hunb_q <= 1'b0;
      end
      // Restart the segment at the previous key
      if (ctl.emit_c) begin
        okey_q  <= prev_q;
        orank_q <= rank_q - RANK_BITS'(1);
        lunb_q  <= 1'b1;
        hunb_q  <= 1'b1;
        slo_q   <= '0;
        shi_q   <= '0;
      end
      if (ctl.post) begin
        prev_q <= key_q;
        rank_q <= rank_q + RANK_BITS'(1);
      end
      // Drop the stream state after the final flush
      if (ctl.emit_f) begin
        started_q <= 1'b0;
        rank_q    <= '0;
        orank_q   <= '0;
        okey_q    <= '0;
        prev_q    <= '0;
        slo_q     <= '0;
        shi_q     <= '0;
        lunb_q    <= 1'b1;
        hunb_q    <= 1'b1;
      end
      if (ctl.emit_c || ctl.emit_f) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the accepted word and the output word
  always_ff @(posedge clk_i) begin
    if (ctl.take) begin
      key_q  <= in_i.key;
      last_q <= in_i.last_key;
    end
    if (ctl.emit_c || ctl.emit_f) begin
      out_key_q   <= okey_q;
      out_slope_q <= cone_slope;
      out_rank_q  <= orank_ext[31:0];
      out_lor_q   <= ctl.emit_f || !last_q;
      out_fin_q   <= ctl.emit_f;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.seg_key       = out_key_q;
  assign out_o.slope         = out_slope_q;
  assign out_o.seg_rank      = out_rank_q;
  assign out_o.last_of_run   = out_lor_q;
  assign out_o.final_segment = out_fin_q;
endmodule
`default_nettype wire

>>> hdl/scs_div.sv
// Bit-serial restoring divider: nmag * 2^FRAC / dmag, signed, saturated to 64 bits
`default_nettype none
module scs_div #(
  parameter int unsigned NB   = 33,
  parameter int unsigned FRAC = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NB-1:0] nmag_i,
  input  wire logic          nneg_i,
  input  wire logic [63:0]   dmag_i,
  input  wire logic          dneg_i,
  output logic               done_o,
  output logic [63:0]        quo_o
);
  import scs_pkg::*;

  localparam int unsigned W  = NB + FRAC;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  num_q, num_d;
  logic [64:0]   rem_q, rem_d;
  logic [63:0]   q_q, q_d, dmag_q, dmag_d;
  logic          sat_q, sat_d, neg_q, neg_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [64:0]   rem_sh;
  logic          ge;

  // One quotient bit per cycle
  assign rem_sh = {rem_q[63:0], num_q[W-1]};
  assign ge     = rem_sh >= {1'b0, dmag_q};

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    q_d    = q_q;
    sat_d  = sat_q;
    neg_d  = neg_q;
    dmag_d = dmag_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = {nmag_i, {FRAC{1'b0}}};
      rem_d  = '0;
      q_d    = '0;
      sat_d  = 1'b0;
      neg_d  = nneg_i ^ dneg_i;
      dmag_d = dmag_i;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[W-2:0], 1'b0};
      rem_d = ge ? rem_sh - {1'b0, dmag_q} : rem_sh;
      sat_d = sat_q | q_q[63];
      q_d   = {q_q[62:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    q_q    <= q_d;
    sat_q  <= sat_d;
    neg_q  <= neg_d;
    dmag_q <= dmag_d;
  end

  // Apply sign and saturate
  always_comb begin
    if (q_q == '0) begin
      quo_o = '0;
    end else if (neg_q) begin
      quo_o = (sat_q || q_q > SlopeMin) ? SlopeMin : (64'd0 - q_q);
    end else begin
      quo_o = (sat_q || q_q[63]) ? SlopeMax : q_q;
    end
  end

  assign done_o = done_q;
endmodule
`default_nettype wire

>>> hdl/scs_checker.sv
// Port-level checker of the segmenter and its bind
`default_nettype none
`include "assert_macros.svh"
module scs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [63:0] out_slope_i,
  input wire logic        out_lor_i,
  input wire logic        out_fin_i
);
  // A stalled word keeps its slope
  `SCS_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_slope_i), "stalled output word changed")
  // A final segment always closes its run
  `SCS_ASSERT(a_fin_lor, out_valid_i && out_fin_i |-> out_lor_i, "final segment without last_of_run")
  // One key in work at a time
  `SCS_ASSERT(a_one_key, in_valid_i && in_ready_i |=> !in_ready_i, "input taken while a key is in work")
  // No word leaves reset valid
  `SCS_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_i, "output valid during reset")
endmodule

bind shrinking_cone_segmenter scs_checker u_scs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_slope_i (out_o.slope),
  .out_lor_i   (out_o.last_of_run),
  .out_fin_i   (out_o.final_segment)
);
`default_nettype wire
